/* hdl/jlsp_pkg.sv */
// Shared constants for the jerk-limited speed profile core.
package jlsp_pkg;

    // Fixed-point format and counter width.
    localparam int FRAC_BITS       = 16;
    localparam int HOLD_COUNT_BITS = 16;

    // Field and register widths.
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 31;
    localparam int WIDE_W  = 64;
    localparam int OUT_W   = 72;
    localparam int ADDR_W  = 3;

    // Commanded speed is clamped to plus or minus 500.0.
    localparam logic signed [DATA_W-1:0] SPEED_LIMIT = DATA_W'(500 << FRAC_BITS);

    // Register reset values: 50.0 and 200.0.
    localparam logic [CFG_W-1:0] RESET_ACCEL = CFG_W'(50 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RESET_JERK  = CFG_W'(200 << FRAC_BITS);

    // Register indexes.
    localparam logic REG_MAX_ACCEL  = 1'b0;
    localparam logic REG_JERK_LIMIT = 1'b1;

    // Profile phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RAMP = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;
    localparam logic [1:0] PH_DOWN = 2'd3;

    // Step counts of the serial units.
    localparam logic [6:0] MUL_LAST  = 7'd32;
    localparam logic [6:0] DIV_LAST  = 7'd64;
    localparam logic [6:0] SQRT_LAST = 7'd32;

endpackage

/* hdl/jerk_limited_speed_profile_core.sv */
// Jerk-limited S-curve speed profile generator with bit-serial planning units.

// One input beat is one control tick and gives exactly one result beat. A tick
// whose clamped target equals the previous one passes through the update
// states UPD1, UPD2 and UPD3 to the output state; a tick with a new target
// first replans, with an extra multiply and extra divides when a profile is
// running. Replanning uses the bit-serial 64x32 multiplier, the restoring
// divider and the square-root unit, which all step one bit per cycle under
// one shared step counter. The next input beat is taken while a finished
// result beat still waits.
module jerk_limited_speed_profile_core
    import jlsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel; tdata: target_speed[31:0].
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    // Result channel; tdata: speed_out[31:0], accel_out[63:32], phase[65:64].
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Sequencer state codes.
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_MUL_AA    = 5'd1;
    localparam logic [4:0] ST_MUL_CC    = 5'd2;
    localparam logic [4:0] ST_DIV_STEP  = 5'd3;
    localparam logic [4:0] ST_DIV_ST2   = 5'd4;
    localparam logic [4:0] ST_DIV_DSTEP = 5'd5;
    localparam logic [4:0] ST_BR0       = 5'd6;
    localparam logic [4:0] ST_BR1S      = 5'd7;
    localparam logic [4:0] ST_BR1       = 5'd8;
    localparam logic [4:0] ST_DIV_HOLD  = 5'd9;
    localparam logic [4:0] ST_MUL_XJ    = 5'd10;
    localparam logic [4:0] ST_SQRT      = 5'd11;
    localparam logic [4:0] ST_GOAL      = 5'd12;
    localparam logic [4:0] ST_UPD1      = 5'd13;
    localparam logic [4:0] ST_UPD2      = 5'd14;
    localparam logic [4:0] ST_UPD3      = 5'd15;
    localparam logic [4:0] ST_OUT       = 5'd16;

    logic [4:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;

    logic [CFG_W-1:0] max_accel_reg, max_accel_next;
    logic [CFG_W-1:0] jerk_limit_reg, jerk_limit_next;

    logic signed [DATA_W-1:0] speed_reg, speed_next;
    logic signed [DATA_W-1:0] accel_reg, accel_next;
    logic signed [DATA_W-1:0] goal_reg, goal_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic [1:0]  phase_reg, phase_next;
    logic [HOLD_COUNT_BITS-1:0] hold_cnt_reg, hold_cnt_next;
    logic [HOLD_COUNT_BITS-1:0] hold_lim_reg, hold_lim_next;
    logic        dir_reg, dir_next;
    logic        decel_reg, decel_next;
    logic [CFG_W-1:0] jerk_held_reg, jerk_held_next;

    logic signed [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W:0]          ad_reg, ad_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] jstep_reg, jstep_next;

    logic [WIDE_W-1:0]        a2_reg, a2_next;
    logic [WIDE_W-1:0]        c2_reg, c2_next;
    logic [WIDE_W-1:0]        step_reg, step_next;
    logic signed [WIDE_W-1:0] st2_reg, st2_next;
    logic [WIDE_W-1:0]        dstep_reg, dstep_next;
    logic [WIDE_W-1:0]        sdist_reg, sdist_next;
    logic [DATA_W-1:0]        mag_reg, mag_next;

    logic [WIDE_W-1:0] mul_m_reg, mul_m_next;
    logic [DATA_W-1:0] mul_b_reg, mul_b_next;
    logic [WIDE_W:0]   mul_hi_reg, mul_hi_next;
    logic [DATA_W-1:0] mul_lo_reg, mul_lo_next;
    logic              mul_sat_reg, mul_sat_next;

    logic [WIDE_W-1:0] div_dvd_reg, div_dvd_next;
    logic [DATA_W-1:0] div_dvsr_reg, div_dvsr_next;
    logic [DATA_W-1:0] div_rem_reg, div_rem_next;

    logic [WIDE_W-1:0] sq_v_reg, sq_v_next;
    logic [WIDE_W-1:0] sq_r_reg, sq_r_next;
    logic [WIDE_W-1:0] sq_bit_reg, sq_bit_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // Serial unit step results.
    logic [WIDE_W+1:0] mul_sum;
    logic [WIDE_W-1:0] mul_prod;
    logic              mul_ovf;
    logic [DATA_W:0]   div_rem_sh;
    logic              div_ge;
    logic [DATA_W:0]   div_rem_sub;
    logic [WIDE_W-1:0] sq_trial;
    logic              sq_ge;

    // Decoded helpers.
    logic signed [DATA_W-1:0] t_in, t_clamp;
    logic signed [DATA_W:0]   t_diff;
    logic [DATA_W-1:0]        two_j;
    logic [DATA_W-1:0]        abs_acc;
    logic [WIDE_W-1:0]        ad64;
    logic [WIDE_W-1:0]        two_step;
    logic [CFG_W-1:0]         jh;
    logic signed [DATA_W:0]   ga_diff;
    logic [DATA_W:0]          ga_abs;
    logic [DATA_W-1:0]        acc_abs_now;
    logic signed [WIDE_W-1:0] st2_sum;
    logic                     same_sign, flip;
    logic [DATA_W-1:0]        mag_sat;
    logic [HOLD_COUNT_BITS-1:0] hold_sat, hold_inc;
    logic signed [DATA_W-1:0] accel_fin, speed_fin;
    logic                     cfg_wr;
    logic [CFG_W-1:0]         cfg_val;
    logic                     out_free;

    // Shift-add multiplier step: one multiplier bit per cycle.
    assign mul_sum  = {1'b0, mul_hi_reg} + (mul_b_reg[0] ? {2'b00, mul_m_reg} : '0);
    assign mul_prod = {mul_hi_reg[DATA_W-1:0], mul_lo_reg};
    assign mul_ovf  = |mul_hi_reg[WIDE_W:DATA_W];

    // Restoring divider step: one quotient bit per cycle.
    assign div_rem_sh  = {div_rem_reg, div_dvd_reg[WIDE_W-1]};
    assign div_ge      = div_rem_sh >= {1'b0, div_dvsr_reg};
    assign div_rem_sub = div_rem_sh - {1'b0, div_dvsr_reg};

    // Square-root step: one result bit per cycle.
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign sq_ge    = sq_v_reg >= sq_trial;

    // Input clamp and distance to the target.
    assign t_in    = $signed(s_tdata);
    assign t_clamp = (t_in > SPEED_LIMIT) ? SPEED_LIMIT :
                     (t_in < -SPEED_LIMIT) ? -SPEED_LIMIT : t_in;
    assign t_diff  = {t_clamp[DATA_W-1], t_clamp} - {speed_reg[DATA_W-1], speed_reg};

    assign two_j    = {jerk_limit_reg, 1'b0};
    assign abs_acc  = accel_reg[DATA_W-1] ? (DATA_W'(0) - accel_reg) : accel_reg;
    assign ad64     = {{(WIDE_W-DATA_W-1){1'b0}}, ad_reg};
    assign two_step = {step_reg[WIDE_W-2:0], 1'b0};
    assign jh       = (jerk_held_reg == '0) ? CFG_W'(1) : jerk_held_reg;
    assign ga_diff  = {goal_reg[DATA_W-1], goal_reg} - {accel_reg[DATA_W-1], accel_reg};
    assign ga_abs   = ga_diff[DATA_W] ? (-ga_diff) : ga_diff;
    assign acc_abs_now = abs_acc;
    assign st2_sum  = st2_reg + $signed(step_reg);

    // Sign relation used for the overshoot branch of a running replan.
    assign same_sign = (accel_reg > 0 && speed_reg > 0) || (accel_reg < 0 && speed_reg < 0);
    assign flip      = decel_reg ? !same_sign : same_sign;

    assign mag_sat  = mag_reg[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : mag_reg;
    assign hold_sat = (|div_dvd_reg[WIDE_W-1:HOLD_COUNT_BITS]) ? '1
                                                             : div_dvd_reg[HOLD_COUNT_BITS-1:0];
    assign hold_inc = hold_cnt_reg + HOLD_COUNT_BITS'(1);

    assign accel_fin = accel_reg + jstep_reg;
    assign speed_fin = speed_reg + accel_fin;

    // Configuration port.
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = (pwdata[CFG_W-1:0] == '0) ? CFG_W'(1) : pwdata[CFG_W-1:0];
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_JERK_LIMIT) ? {1'b0, jerk_limit_reg}
                                                 : {1'b0, max_accel_reg};

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer and datapath next values.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        max_accel_next  = max_accel_reg;
        jerk_limit_next = jerk_limit_reg;
        speed_next      = speed_reg;
        accel_next      = accel_reg;
        goal_next       = goal_reg;
        prev_next       = prev_reg;
        phase_next      = phase_reg;
        hold_cnt_next   = hold_cnt_reg;
        hold_lim_next   = hold_lim_reg;
        dir_next        = dir_reg;
        decel_next      = decel_reg;
        jerk_held_next  = jerk_held_reg;
        t_next          = t_reg;
        ad_next         = ad_reg;
        neg_next        = neg_reg;
        jstep_next      = jstep_reg;
        a2_next         = a2_reg;
        c2_next         = c2_reg;
        step_next       = step_reg;
        st2_next        = st2_reg;
        dstep_next      = dstep_reg;
        sdist_next      = sdist_reg;
        mag_next        = mag_reg;
        mul_m_next      = mul_m_reg;
        mul_b_next      = mul_b_reg;
        mul_hi_next     = mul_hi_reg;
        mul_lo_next     = mul_lo_reg;
        mul_sat_next    = mul_sat_reg;
        div_dvd_next    = div_dvd_reg;
        div_dvsr_next   = div_dvsr_reg;
        div_rem_next    = div_rem_reg;
        sq_v_next       = sq_v_reg;
        sq_r_next       = sq_r_reg;
        sq_bit_next     = sq_bit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        // Register writes; the user must use the port only while no tick is in flight (not enforced).
        if (cfg_wr) begin
            if (paddr[2] == REG_JERK_LIMIT) begin
                jerk_limit_next = cfg_val;
            end else begin
                max_accel_next = cfg_val;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    t_next     = t_clamp;
                    jstep_next = '0;
                    if (t_clamp != prev_reg) begin
                        // New target: pick direction and mode, then start A*A.
                        ad_next  = t_diff[DATA_W] ? (DATA_W+1)'(0) - t_diff : t_diff;
                        dir_next = !(t_clamp > speed_reg);
                        neg_next = !(t_clamp > speed_reg);
                        if (speed_reg > 0) begin
                            decel_next = !(t_clamp > speed_reg);
                        end else if (speed_reg < 0) begin
                            decel_next = (t_clamp > speed_reg);
                        end else begin
                            decel_next = 1'b0;
                        end
                        mul_m_next   = {{(WIDE_W-CFG_W){1'b0}}, max_accel_reg};
                        mul_b_next   = {1'b0, max_accel_reg};
                        mul_hi_next  = '0;
                        mul_lo_next  = '0;
                        mul_sat_next = 1'b0;
                        cnt_next     = '0;
                        state_next   = ST_MUL_AA;
                    end else begin
                        state_next = ST_UPD1;
                    end
                end
            end

            ST_MUL_AA, ST_MUL_CC, ST_MUL_XJ: begin
                if (cnt_reg != MUL_LAST) begin
                    mul_hi_next = mul_sum[WIDE_W+1:1];
                    mul_lo_next = {mul_sum[0], mul_lo_reg[DATA_W-1:1]};
                    mul_b_next  = {1'b0, mul_b_reg[DATA_W-1:1]};
                    cnt_next    = cnt_reg + 7'd1;
                end else begin
                    cnt_next = '0;
                    if (state_reg == ST_MUL_AA) begin
                        a2_next = mul_prod;
                        if (phase_reg != PH_IDLE) begin
                            // Running profile: also need the present accel squared.
                            mul_m_next  = {{(WIDE_W-DATA_W){1'b0}}, acc_abs_now};
                            mul_b_next  = acc_abs_now;
                            mul_hi_next = '0;
                            mul_lo_next = '0;
                            state_next  = ST_MUL_CC;
                        end else begin
                            div_dvd_next  = mul_prod;
                            div_dvsr_next = two_j;
                            div_rem_next  = '0;
                            state_next    = ST_DIV_STEP;
                        end
                    end else if (state_reg == ST_MUL_CC) begin
                        c2_next       = mul_prod;
                        div_dvd_next  = a2_reg;
                        div_dvsr_next = two_j;
                        div_rem_next  = '0;
                        state_next    = ST_DIV_STEP;
                    end else begin
                        // Product X*J feeds the square root, saturated on request.
                        sq_v_next   = (mul_sat_reg && mul_ovf) ? '1 : mul_prod;
                        sq_r_next   = '0;
                        sq_bit_next = WIDE_W'(1) << (WIDE_W - 2);
                        state_next  = ST_SQRT;
                    end
                end
            end

            ST_DIV_STEP, ST_DIV_ST2, ST_DIV_DSTEP, ST_DIV_HOLD: begin
                if (cnt_reg != DIV_LAST) begin
                    div_rem_next = div_ge ? div_rem_sub[DATA_W-1:0] : div_rem_sh[DATA_W-1:0];
                    div_dvd_next = {div_dvd_reg[WIDE_W-2:0], div_ge};
                    cnt_next     = cnt_reg + 7'd1;
                end else begin
                    cnt_next     = '0;
                    div_rem_next = '0;
                    if (state_reg == ST_DIV_STEP) begin
                        step_next = div_dvd_reg;
                        if (phase_reg == PH_IDLE) begin
                            state_next = ST_BR0;
                        end else begin
                            div_dvd_next = (c2_reg > a2_reg) ? c2_reg - a2_reg : a2_reg - c2_reg;
                            state_next   = ST_DIV_ST2;
                        end
                    end else if (state_reg == ST_DIV_ST2) begin
                        // Signed quotient truncates toward zero.
                        st2_next     = (c2_reg > a2_reg) ? -$signed(div_dvd_reg)
                                                         : $signed(div_dvd_reg);
                        div_dvd_next = c2_reg;
                        state_next   = ST_DIV_DSTEP;
                    end else if (state_reg == ST_DIV_DSTEP) begin
                        dstep_next = div_dvd_reg;
                        state_next = ST_BR1S;
                    end else begin
                        hold_lim_next = hold_sat;
                        mag_next      = {1'b0, max_accel_reg};
                        state_next    = ST_GOAL;
                    end
                end
            end

            ST_BR0: begin
                // Idle start: a hold at full acceleration between the ramps if the distance exceeds both ramps.
                if (ad64 > two_step) begin
                    div_dvd_next  = ad64 - two_step;
                    div_dvsr_next = {1'b0, max_accel_reg};
                    div_rem_next  = '0;
                    state_next    = ST_DIV_HOLD;
                end else begin
                    hold_lim_next = '0;
                    mul_m_next    = ad64;
                    mul_b_next    = {1'b0, jerk_limit_reg};
                    mul_hi_next   = '0;
                    mul_lo_next   = '0;
                    mul_sat_next  = 1'b0;
                    state_next    = ST_MUL_XJ;
                end
                cnt_next = '0;
            end

            ST_BR1S: begin
                sdist_next = st2_sum[WIDE_W-1] ? WIDE_W'(0) - st2_sum : st2_sum;
                state_next = ST_BR1;
            end

            ST_BR1: begin
                // Running replan: full ramps, square-root peak, or overshoot case.
                hold_cnt_next = '0;
                cnt_next      = '0;
                mul_b_next    = {1'b0, jerk_limit_reg};
                mul_hi_next   = '0;
                mul_lo_next   = '0;
                if (ad64 > sdist_reg) begin
                    div_dvd_next  = ad64 - sdist_reg;
                    div_dvsr_next = {1'b0, max_accel_reg};
                    div_rem_next  = '0;
                    state_next    = ST_DIV_HOLD;
                end else if (ad64 > dstep_reg) begin
                    hold_lim_next = '0;
                    mul_m_next    = ad64 + dstep_reg;
                    mul_sat_next  = 1'b0;
                    state_next    = ST_MUL_XJ;
                end else begin
                    hold_lim_next = '0;
                    mul_m_next    = flip ? dstep_reg - ad64 : ad64 + dstep_reg;
                    mul_sat_next  = 1'b1;
                    neg_next      = neg_reg ^ flip;
                    state_next    = ST_MUL_XJ;
                end
            end

            ST_SQRT: begin
                if (cnt_reg != SQRT_LAST) begin
                    if (sq_ge) begin
                        sq_v_next = sq_v_reg - sq_trial;
                        sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_r_next = sq_r_reg >> 1;
                    end
                    sq_bit_next = sq_bit_reg >> 2;
                    cnt_next    = cnt_reg + 7'd1;
                end else begin
                    cnt_next   = '0;
                    mag_next   = sq_r_reg[DATA_W-1:0];
                    state_next = ST_GOAL;
                end
            end

            ST_GOAL: begin
                goal_next      = neg_reg ? DATA_W'(0) - mag_sat : mag_sat;
                jerk_held_next = jerk_limit_reg;
                phase_next     = PH_RAMP;
                prev_next      = t_reg;
                state_next     = ST_UPD1;
            end

            ST_UPD1: begin
                // Ramp the acceleration toward the goal.
                if (phase_reg == PH_RAMP) begin
                    if (ga_abs < {2'b00, jh}) begin
                        accel_next = goal_reg;
                        jstep_next = '0;
                        phase_next = PH_HOLD;
                    end else begin
                        jstep_next = (goal_reg > accel_reg) ? $signed({1'b0, jh})
                                                            : -$signed({1'b0, jh});
                    end
                end
                state_next = ST_UPD2;
            end

            ST_UPD2: begin
                // Hold the acceleration for the counted number of ticks.
                if (phase_reg == PH_HOLD) begin
                    jstep_next = '0;
                    if (hold_inc >= hold_lim_reg) begin
                        hold_cnt_next = '0;
                        goal_next     = '0;
                        phase_next    = PH_DOWN;
                    end else begin
                        hold_cnt_next = hold_inc;
                    end
                end
                state_next = ST_UPD3;
            end

            ST_UPD3: begin
                // Ramp the acceleration back to zero and land on the target.
                if (phase_reg == PH_DOWN) begin
                    if ({1'b0, acc_abs_now} < {2'b00, jh}) begin
                        accel_next = '0;
                        jstep_next = '0;
                        phase_next = PH_IDLE;
                        speed_next = t_reg;
                    end else begin
                        jstep_next = (accel_reg > 0) ? -$signed({1'b0, jh})
                                                     : $signed({1'b0, jh});
                    end
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                // Integrate and hand the beat to the output register.
                if (out_free) begin
                    accel_next    = accel_fin;
                    speed_next    = speed_fin;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, phase_reg, accel_fin, speed_fin};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            max_accel_reg  <= RESET_ACCEL;
            jerk_limit_reg <= RESET_JERK;
            speed_reg      <= '0;
            accel_reg      <= '0;
            goal_reg       <= '0;
            prev_reg       <= '0;
            phase_reg      <= PH_IDLE;
            hold_cnt_reg   <= '0;
            hold_lim_reg   <= '0;
            dir_reg        <= 1'b0;
            decel_reg      <= 1'b0;
            jerk_held_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            max_accel_reg  <= max_accel_next;
            jerk_limit_reg <= jerk_limit_next;
            speed_reg      <= speed_next;
            accel_reg      <= accel_next;
            goal_reg       <= goal_next;
            prev_reg       <= prev_next;
            phase_reg      <= phase_next;
            hold_cnt_reg   <= hold_cnt_next;
            hold_lim_reg   <= hold_lim_next;
            dir_reg        <= dir_next;
            decel_reg      <= decel_next;
            jerk_held_reg  <= jerk_held_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Working registers of the planner and the serial units.
    always_ff @(posedge aclk) begin
        t_reg        <= t_next;
        ad_reg       <= ad_next;
        neg_reg      <= neg_next;
        jstep_reg    <= jstep_next;
        a2_reg       <= a2_next;
        c2_reg       <= c2_next;
        step_reg     <= step_next;
        st2_reg      <= st2_next;
        dstep_reg    <= dstep_next;
        sdist_reg    <= sdist_next;
        mag_reg      <= mag_next;
        mul_m_reg    <= mul_m_next;
        mul_b_reg    <= mul_b_next;
        mul_hi_reg   <= mul_hi_next;
        mul_lo_reg   <= mul_lo_next;
        mul_sat_reg  <= mul_sat_next;
        div_dvd_reg  <= div_dvd_next;
        div_dvsr_reg <= div_dvsr_next;
        div_rem_reg  <= div_rem_next;
        sq_v_reg     <= sq_v_next;
        sq_r_reg     <= sq_r_next;
        sq_bit_reg   <= sq_bit_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // A finished plan always starts the ramp phase.
    a_goal_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_GOAL |=> phase_reg == PH_RAMP)
        else $error("plan did not enter ramp phase");

    // With no profile running and nothing in flight, the acceleration is zero.
    a_idle_accel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && phase_reg == PH_IDLE) |-> accel_reg == '0)
        else $error("acceleration not zero while idle");

    // The shared step counter never runs past the longest unit.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DIV_LAST)
        else $error("step counter out of range");

endmodule

/* verif/jerk_limited_speed_profile_core_test.sv */
// Self-checking testbench for the jerk-limited speed profile core.
module jerk_limited_speed_profile_core_test;
    import jlsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected speed, acceleration and phase of one tick.
    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] accel;
        logic [31:0] speed;
    } tick_result_t;

    // Profile predictor plus the queue of ticks whose results are still due.
    class profile_scoreboard;
        logic [30:0]  max_accel;
        logic [30:0]  jerk_limit;
        logic [31:0]  speed_now, accel_now, accel_goal, prev_target, jerk_held;
        logic [1:0]   prof_phase;
        logic [15:0]  hold_count, hold_limit;
        bit           move_neg, decel;
        tick_result_t due_q[$];
        int           errors;
        int           checked;

        function new();
            max_accel   = RESET_ACCEL;
            jerk_limit  = RESET_JERK;
            speed_now   = '0;
            accel_now   = '0;
            accel_goal  = '0;
            prev_target = '0;
            jerk_held   = '0;
            prof_phase  = PH_IDLE;
            hold_count  = '0;
            hold_limit  = '0;
            move_neg    = 0;
            decel       = 0;
            errors      = 0;
            checked     = 0;
        endfunction

        // A zero write stores one.
        function void set_reg(logic idx, logic [31:0] value);
            logic [30:0] v;
            v = value[30:0];
            if (v == '0) v = 31'd1;
            if (idx == REG_MAX_ACCEL) max_accel = v;
            else jerk_limit = v;
        endfunction

        static function longint unsigned mag64(longint v);
            return (v < 0) ? longint'(unsigned'(0)) - v : v;
        endfunction

        static function longint unsigned root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        static function logic [15:0] hold_ticks(longint unsigned rest, longint unsigned a);
            longint unsigned q;
            q = rest / a;
            return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        endfunction

        // Advance the profile by one tick and queue its result.
        function void note_tick(logic [31:0] din);
            longint t, spd, acc, av, gv, jv, st2, lim;
            longint unsigned ad, ax, jx, a2, c2, ramp, mag, s, dstep, inner, prod;
            bit neg, same, flip;
            logic [31:0] jh;
            tick_result_t r;
            lim = longint'(SPEED_LIMIT);
            t = longint'(signed'(din));
            jv = 0;
            if (t > lim) t = lim;
            if (t < -lim) t = -lim;
            // A new target replans the profile.
            if (t != longint'(signed'(prev_target))) begin
                spd  = longint'(signed'(speed_now));
                acc  = longint'(signed'(accel_now));
                ad   = mag64(t - spd);
                ax   = max_accel;
                jx   = jerk_limit;
                a2   = ax * ax;
                c2   = acc * acc;
                ramp = a2 / (2 * jx);
                if (spd > 0) begin
                    decel = !(t > spd);
                end else if (spd < 0) begin
                    decel = (t > spd);
                end else begin
                    decel = 0;
                end
                move_neg = !(t > spd);
                neg = move_neg;
                if (prof_phase == PH_IDLE) begin
                    if (ad > 2 * ramp) begin
                        hold_limit = hold_ticks(ad - 2 * ramp, ax);
                        mag = ax;
                    end else begin
                        hold_limit = '0;
                        mag = root64(ad * jx);
                    end
                end else begin
                    st2   = (longint'(a2) - longint'(c2)) / longint'(2 * jx);
                    s     = mag64(st2 + longint'(ramp));
                    dstep = c2 / (2 * jx);
                    if (ad > s) begin
                        hold_limit = hold_ticks(ad - s, ax);
                        mag = ax;
                    end else if (ad > dstep) begin
                        hold_limit = '0;
                        mag = root64((ad + dstep) * jx);
                    end else begin
                        same  = (acc > 0 && spd > 0) || (acc < 0 && spd < 0);
                        flip  = decel ? !same : same;
                        inner = flip ? dstep - ad : ad + dstep;
                        hold_limit = '0;
                        // Saturate the product before the root.
                        if (inner != 0 && jx > 64'hFFFF_FFFF_FFFF_FFFF / inner)
                            prod = 64'hFFFF_FFFF_FFFF_FFFF;
                        else
                            prod = inner * jx;
                        mag = root64(prod);
                        neg = neg != flip;
                    end
                    hold_count = '0;
                end
                if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                accel_goal  = neg ? 32'd0 - mag[31:0] : mag[31:0];
                jerk_held   = {1'b0, jerk_limit};
                prof_phase  = PH_RAMP;
                prev_target = t[31:0];
            end

            jh = (jerk_held != 0) ? jerk_held : 32'd1;
            if (prof_phase == PH_RAMP) begin
                av = longint'(signed'(accel_now));
                gv = longint'(signed'(accel_goal));
                jv = (gv > av) ? longint'(jh) : -longint'(jh);
                if (mag64(gv - av) < longint'(jh)) begin
                    accel_now  = accel_goal;
                    jv         = 0;
                    prof_phase = PH_HOLD;
                end
            end
            if (prof_phase == PH_HOLD) begin
                jv = 0;
                hold_count = hold_count + 16'd1;
                if (hold_count >= hold_limit) begin
                    hold_count = '0;
                    accel_goal = '0;
                    prof_phase = PH_DOWN;
                end
            end
            if (prof_phase == PH_DOWN) begin
                av = longint'(signed'(accel_now));
                jv = (av > 0) ? -longint'(jh) : longint'(jh);
                if (mag64(av) < longint'(jh)) begin
                    accel_now  = '0;
                    jv         = 0;
                    prof_phase = PH_IDLE;
                    speed_now  = t[31:0];
                end
            end
            accel_now = accel_now + jv[31:0];
            speed_now = speed_now + accel_now;
            r.speed = speed_now;
            r.accel = accel_now;
            r.phase = prof_phase;
            due_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest expected tick.
        function void check_beat(logic [OUT_W-1:0] beat);
            tick_result_t e, a;
            a = beat[65:0];
            checked++;
            if (due_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, a);
                return;
            end
            e = due_q.pop_front();
            if (a.speed !== e.speed) begin
                errors++;
                $display("%0t: speed expected %h actual %h", $time, e.speed, a.speed);
            end
            if (a.accel !== e.accel) begin
                errors++;
                $display("%0t: accel expected %h actual %h", $time, e.accel, a.accel);
            end
            if (a.phase !== e.phase) begin
                errors++;
                $display("%0t: phase expected %0d actual %0d", $time, e.phase, a.phase);
            end
        endfunction
    endclass

    localparam int ITEMS_PER_PHASE = 500;
    localparam int STALL_LIMIT     = 20000;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    profile_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;
    int quiet_cycles;

    jerk_limited_speed_profile_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver back-pressure follows the current stall rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("jerk_limited_speed_profile_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one tick, with a random gap ahead of it.
    task automatic send_tick(input logic [31:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(v);
        sent++;
    endtask

    task automatic drain();
        while (sb.due_q.size() != 0) @(posedge aclk);
    endtask

    // Register write while the core is idle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        drain();
        repeat (8) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // A mix of held targets, speed-equal targets, wild values and jitter.
    task automatic random_ticks(input int count);
        int kind;
        int n;
        logic [31:0] v;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                v = $urandom_range(1200 << 16) - (600 << 16);
                repeat ($urandom_range(1, 30)) begin
                    send_tick(v);
                    n++;
                end
            end else if (kind < 80) begin
                send_tick(sb.speed_now);
                n++;
            end else if (kind < 90) begin
                send_tick($urandom);
                n++;
            end else begin
                v = sb.prev_target + $urandom_range(1 << 17) - (1 << 16);
                send_tick(v);
                n++;
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        sent     = 0;
        quiet_cycles = 0;
        send_idle_pct  = 32;
        recv_stall_pct = 80;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, clamping, repeats and replans mid-motion.
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h8000_0000);
        send_tick(32'h0000_0000);
        send_tick(32'h01F4_0000);
        send_tick(32'hFE0C_0000);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0001);
        send_tick(32'h0000_0001);
        // Target equal to the running speed, positive and negative.
        send_tick(32'h0064_0000);
        send_tick(sb.speed_now);
        send_tick(32'hFF9C_0000);
        send_tick(sb.speed_now);
        repeat (6) send_tick(32'h0000_0000);
        // Hold until every result is back.
        s_tvalid <= 1'b0;
        drain();
        random_ticks(ITEMS_PER_PHASE);

        // Tiny acceleration with the largest jerk, zero write included.
        send_idle_pct  = 80;
        recv_stall_pct = 32;
        write_reg(REG_MAX_ACCEL, 32'h0000_0000);
        write_reg(REG_JERK_LIMIT, 32'hFFFF_FFFF);
        send_tick(32'h01F4_0000);
        send_tick(32'hFE0C_0000);
        random_ticks(ITEMS_PER_PHASE / 2);
        write_reg(REG_MAX_ACCEL, $urandom_range(1 << 14, 100 << 16));
        write_reg(REG_JERK_LIMIT, $urandom_range(1 << 14, 400 << 16));
        random_ticks(ITEMS_PER_PHASE / 2);

        // Largest acceleration with the smallest, then the largest jerk; then ordinary settings.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_MAX_ACCEL, 32'h7FFF_FFFF);
        write_reg(REG_JERK_LIMIT, 32'h0000_0000);
        random_ticks(ITEMS_PER_PHASE / 4);
        write_reg(REG_JERK_LIMIT, 32'h7FFF_FFFF);
        random_ticks(ITEMS_PER_PHASE / 4);
        write_reg(REG_MAX_ACCEL, $urandom_range(1 << 14, 100 << 16));
        write_reg(REG_JERK_LIMIT, $urandom_range(1 << 10, 50 << 16));
        random_ticks(ITEMS_PER_PHASE / 2);

        s_tvalid <= 1'b0;
        drain();
        repeat (50) @(posedge aclk);
        $display("Sent %0d ticks over six register settings, checked %0d result beats.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("jerk_limited_speed_profile_core regression: pass");
        end else begin
            $display("jerk_limited_speed_profile_core regression: fail");
        end
        $finish;
    end

endmodule
